@@ hdl/gdgt_pkg.sv @@
package gdgt_pkg;

    localparam int PIX_W      = 32;
    localparam int CHAN_W     = 8;
    localparam int WIDTH_W    = 12;
    localparam int GREY_W     = 8;
    localparam int SUM_W      = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OUT_WIDTH  = 2'd0,
        CFG_TINT_RED   = 2'd1,
        CFG_TINT_GREEN = 2'd2,
        CFG_TINT_BLUE  = 2'd3
    } cfg_reg_t;

    localparam logic [WIDTH_W-1:0] OUT_WIDTH_RESET = 12'd1;
    localparam logic [CHAN_W-1:0]  TINT_RESET      = 8'hFF;

    // floor(x / 3) for x <= 765 is (x * 683) >> 11; the excess of the
    // reciprocal stays below one third of a step over that range.
    localparam int                RGB_SUM_W  = 10;
    localparam int                GREY_PROD_W = 2 * RGB_SUM_W;
    localparam logic [RGB_SUM_W-1:0] GREY_RECIP = 10'd683;
    localparam int                GREY_SHIFT = 11;

    localparam int ALPHA_MIN  = 8;
    localparam int ROM_BIG_W  = 800;

    typedef logic [255:0][CHAN_W-1:0] alpha_rom_t;

    // Entry v is the exactly rounded 255 * (v / 255)^0.82, or zero where that
    // falls below ALPHA_MIN. The threshold test (v/255)^0.82 >= (2k+1)/510 is
    // done as v^41 * 510^50 >= (2k+1)^50 * 255^41 on wide integers at elaboration.
    function automatic alpha_rom_t alpha_rom_build();
        logic [ROM_BIG_W-1:0] base_l;
        logic [ROM_BIG_W-1:0] base_r;
        logic [ROM_BIG_W-1:0] lhs;
        logic [ROM_BIG_W-1:0] rhs;
        alpha_rom_t           rom;
        int                   k;
        bit                   done;
        base_l = ROM_BIG_W'(1);
        for (int i = 0; i < 50; i++)
        begin
            base_l = base_l * ROM_BIG_W'(510);
        end
        base_r = ROM_BIG_W'(1);
        for (int i = 0; i < 41; i++)
        begin
            base_r = base_r * ROM_BIG_W'(255);
        end
        k = 0;
        for (int v = 0; v < 256; v++)
        begin
            lhs = base_l;
            for (int i = 0; i < 41; i++)
            begin
                lhs = lhs * ROM_BIG_W'(v);
            end
            done = 1'b0;
            while ((k < 255) && !done)
            begin
                rhs = base_r;
                for (int i = 0; i < 50; i++)
                begin
                    rhs = rhs * ROM_BIG_W'(2 * k + 1);
                end
                if (lhs < rhs)
                begin
                    done = 1'b1;
                end
                else
                begin
                    k++;
                end
            end
            rom[v] = (k < ALPHA_MIN) ? '0 : CHAN_W'(k);
        end
        return rom;
    endfunction

    localparam alpha_rom_t ALPHA_ROM = alpha_rom_build();

endpackage

@@ hdl/gdgt_ifs.sv @@
interface gdgt_in_if;
    import gdgt_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] src_pixel;
    logic             frame_start;

    modport source (output valid, output src_pixel, output frame_start, input ready);
    modport sink (input valid, input src_pixel, input frame_start, output ready);
endinterface

interface gdgt_out_if;
    import gdgt_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] out_pixel;
    logic             row_end;

    modport source (output valid, output out_pixel, output row_end, input ready);
    modport sink (input valid, input out_pixel, input row_end, output ready);
endinterface

interface gdgt_cfg_if;
    import gdgt_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ hdl/gdgt_ram.sv @@
module gdgt_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // The read data holds while no new read is issued.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/glyph_downsample_gamma_tint_core.sv @@
// Glyph 2x2 downsampler with gamma-shaped alpha and a constant tint.
// Channel src takes supersampled XRGB pixels in raster order, rows of twice
// out_width pixels; frame_start on a request restarts at column 0 of an even
// row. Channel dst delivers one ARGB pixel for every odd column of an odd
// source row, with row_end on the last one of the row; other pixels give none.
// Channel cfg writes out_width and the tint; it is always ready and must only
// be used while no pixel is in flight.
// Throughput is one pixel per clock while dst is not stalled. A result passes
// registered stages in order: the grey multiply and the line store read, then
// the pair sums and the average, then the alpha table. The line store is a
// single memory with one write port and one registered read port, read on odd
// rows and written on even rows. The pipeline moves in lockstep: when dst
// stalls with a result held, src is stalled too, and nothing is lost.
// Reset clears the position to column 0 of an even row and the registers to
// out_width 1 and a white tint. The line store is not cleared; an odd row
// must follow an even row that wrote it.
module glyph_downsample_gamma_tint_core #(
    parameter int MAX_OUT_WIDTH = 2048
) (
    input logic          clk,
    input logic          rst_n,
    gdgt_in_if.sink      src,
    gdgt_out_if.source   dst,
    gdgt_cfg_if.sink     cfg
);
    import gdgt_pkg::*;

    localparam int SLOT_W = $clog2(MAX_OUT_WIDTH);
    localparam int COL_W  = SLOT_W + 1;
    localparam int CMP_W  = (COL_W > WIDTH_W) ? COL_W : WIDTH_W;

    // Configuration.
    logic [WIDTH_W-1:0] width_reg;
    logic [CHAN_W-1:0]  tint_red_reg;
    logic [CHAN_W-1:0]  tint_green_reg;
    logic [CHAN_W-1:0]  tint_blue_reg;

    // Position.
    logic [COL_W-1:0] col_reg;
    logic             row_odd_reg;
    logic [GREY_W-1:0] pair_sum_reg;

    // Pipeline.
    logic              s1_valid_reg;
    logic [GREY_W-1:0] s1_grey_reg;
    logic              s1_odd_col_reg;
    logic              s1_odd_row_reg;
    logic              s1_last_reg;
    logic [SLOT_W-1:0] s1_slot_reg;
    logic              s2_valid_reg;
    logic [GREY_W-1:0] s2_avg_reg;
    logic              s2_last_reg;
    logic              out_valid_reg;
    logic [PIX_W-1:0]  out_pixel_reg;
    logic              out_row_end_reg;

    logic [CMP_W-1:0]       width_ext;
    logic [COL_W-1:0]       w_eff;
    logic [COL_W:0]         two_w;
    logic [COL_W-1:0]       last_col;
    logic [COL_W-1:0]       cur_col;
    logic                   cur_odd_row;
    logic                   at_last;
    logic                   advance;
    logic                   accept;
    logic [RGB_SUM_W-1:0]   rgb_sum;
    logic [GREY_PROD_W-1:0] grey_prod;
    logic [GREY_W-1:0]      grey;
    logic [SUM_W-1:0]       pair_total;
    logic [SUM_W:0]         quad_sum;
    logic [CHAN_W-1:0]      alpha;

    logic              ram_we;
    logic              ram_re;
    logic [SLOT_W-1:0] ram_waddr;
    logic [SLOT_W-1:0] ram_raddr;
    logic [SUM_W-1:0]  ram_rdata;

    // Effective width, clamped to 1 .. MAX_OUT_WIDTH.
    always_comb
    begin
        width_ext = CMP_W'(width_reg);
        priority if (width_ext == '0)
        begin
            w_eff = COL_W'(1);
        end
        else if (width_ext > CMP_W'(MAX_OUT_WIDTH))
        begin
            w_eff = COL_W'(MAX_OUT_WIDTH);
        end
        else
        begin
            w_eff = COL_W'(width_ext);
        end
    end

    assign two_w    = {w_eff, 1'b0};
    assign last_col = COL_W'(two_w - (COL_W + 1)'(1));

    assign cur_col     = src.frame_start ? '0 : col_reg;
    assign cur_odd_row = src.frame_start ? 1'b0 : row_odd_reg;
    assign at_last     = (cur_col >= last_col);

    assign advance   = !out_valid_reg || dst.ready;
    assign accept    = src.valid && advance;
    assign src.ready = advance;
    assign cfg.ready = 1'b1;

    assign rgb_sum = RGB_SUM_W'(src.src_pixel[23:16]) + RGB_SUM_W'(src.src_pixel[15:8])
                   + RGB_SUM_W'(src.src_pixel[7:0]);
    assign grey_prod = GREY_PROD_W'(rgb_sum) * GREY_PROD_W'(GREY_RECIP);
    assign grey      = grey_prod[GREY_SHIFT +: GREY_W];

    // Line store: read at request time for the odd column of an odd row,
    // written one stage later on even rows. The write of a slot lands before
    // the odd row reads it, so no forwarding is needed.
    assign ram_re    = accept && cur_col[0] && cur_odd_row;
    assign ram_raddr = cur_col[COL_W-1:1];
    assign ram_we    = advance && s1_valid_reg && s1_odd_col_reg && !s1_odd_row_reg;
    assign ram_waddr = s1_slot_reg;

    assign pair_total = SUM_W'(pair_sum_reg) + SUM_W'(s1_grey_reg);
    assign quad_sum   = (SUM_W + 1)'(ram_rdata) + (SUM_W + 1)'(pair_total);

    assign alpha = ALPHA_ROM[s2_avg_reg];

    gdgt_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_OUT_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (pair_total),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg      <= OUT_WIDTH_RESET;
            tint_red_reg   <= TINT_RESET;
            tint_green_reg <= TINT_RESET;
            tint_blue_reg  <= TINT_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_reg_t'(cfg.index))
                CFG_OUT_WIDTH:  width_reg      <= cfg.data[WIDTH_W-1:0];
                CFG_TINT_RED:   tint_red_reg   <= cfg.data[CHAN_W-1:0];
                CFG_TINT_GREEN: tint_green_reg <= cfg.data[CHAN_W-1:0];
                CFG_TINT_BLUE:  tint_blue_reg  <= cfg.data[CHAN_W-1:0];
                default:        width_reg      <= width_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_odd_reg   <= 1'b0;
            pair_sum_reg  <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            if (accept)
            begin
                col_reg     <= at_last ? '0 : COL_W'(cur_col + COL_W'(1));
                row_odd_reg <= at_last ? !cur_odd_row : cur_odd_row;
            end
            if (s1_valid_reg && !s1_odd_col_reg)
            begin
                pair_sum_reg <= s1_grey_reg;
            end
            s1_valid_reg  <= accept;
            s2_valid_reg  <= s1_valid_reg && s1_odd_col_reg && s1_odd_row_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_grey_reg    <= grey;
            s1_odd_col_reg <= cur_col[0];
            s1_odd_row_reg <= cur_odd_row;
            s1_last_reg    <= at_last;
            s1_slot_reg    <= cur_col[COL_W-1:1];
            s2_avg_reg     <= quad_sum[SUM_W:2];
            s2_last_reg    <= s1_last_reg;
            out_pixel_reg  <= (alpha == '0) ? '0
                            : {alpha, tint_red_reg, tint_green_reg, tint_blue_reg};
            out_row_end_reg <= s2_last_reg;
        end
    end

    assign dst.valid     = out_valid_reg;
    assign dst.out_pixel = out_pixel_reg;
    assign dst.row_end   = out_row_end_reg;

    // A read and a write of the same line store slot never fall in one cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("line store read and write collide on one slot");

    // A pending average comes only from an odd column of an odd row.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(s2_valid_reg) |-> $past(s1_valid_reg && s1_odd_col_reg && s1_odd_row_reg))
        else $error("average staged from a pixel that completes no block");

    // A transparent result carries no tint.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_pixel_reg[31:24] == '0)) |-> (out_pixel_reg == '0))
        else $error("transparent result with nonzero color");

    // Faint alpha values are cut to zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((out_pixel_reg[31:24] == '0)
                           || (out_pixel_reg[31:24] >= CHAN_W'(ALPHA_MIN))))
        else $error("alpha below the cutoff reached the output");

endmodule
